@@ rtl/rpu_pkg.sv @@
package rpu_pkg;

  localparam int ROT_FRAC_BITS = 30;
  localparam int ACC_W = 40;

  localparam logic [1:0] ACT_LOAD      = 2'd0;
  localparam logic [1:0] ACT_UPDATE    = 2'd1;
  localparam logic [1:0] ACT_TRANSFORM = 2'd2;
  localparam logic [1:0] ACT_IDENTITY  = 2'd3;

  localparam logic [31:0] ONE_ROT = 32'(64'sd1 <<< ROT_FRAC_BITS);

  // one multiply-accumulate request to the shared unit
  typedef struct packed {
    logic              first;
    logic              neg;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mac_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = -ACC_W'(64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ rtl/rpu_mac.sv @@
module rpu_mac import rpu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  mac_req_t                req,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] term;
  logic                    en_d;
  logic                    first_d;
  logic                    neg_d;

  // stage 1: register the product; stage 2: shift (floor) and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      en_d <= 1'b0;
    end else begin
      en_d <= en;
    end
    prod    <= req.a * req.b;
    first_d <= req.first;
    neg_d   <= req.neg;
  end

  assign term = ACC_W'(prod >>> ROT_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en_d) begin
      acc <= (first_d ? '0 : acc) + (neg_d ? -term : term);
    end
  end

endmodule

@@ rtl/rpu_seq.sv @@
module rpu_seq import rpu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              action,
  input  logic [1:0]              row_select,
  input  logic signed [31:0]      vec_x,
  input  logic signed [31:0]      vec_y,
  input  logic signed [31:0]      vec_z,
  input  logic signed [31:0]      quat_x,
  input  logic signed [31:0]      quat_y,
  input  logic signed [31:0]      quat_z,
  input  logic signed [31:0]      quat_w,
  output logic                    mac_en,
  output mac_req_t                mac_req,
  input  logic signed [ACC_W-1:0] acc,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic signed [31:0]      res_x,
  output logic signed [31:0]      res_y,
  output logic signed [31:0]      res_z
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  // flat index of basis entry (row, column), row-major
  function automatic logic [3:0] m_idx(input logic [1:0] r, input logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

  logic [1:0] state;
  logic       is_xf;
  logic [1:0] col;
  logic [1:0] grp;   // which output of the column (or row for transform)
  logic [2:0] term;  // term within the sum, 0..4; it rests at n_terms (3 or 4) while draining
  logic [1:0] phase; // 0 = p stage, 1 = basis stage

  logic signed [31:0] m [9];
  logic signed [31:0] org [3];
  logic signed [31:0] v [3];
  logic signed [31:0] q [4]; // x y z w
  logic signed [31:0] p [4]; // px py pz pw
  logic signed [31:0] res [3];

  logic [2:0] n_terms;
  logic       last_term;
  logic signed [31:0] b0, b1, b2;
  logic signed [31:0] sat_acc;
  logic [1:0] g1, g2;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign res_x = res[0];
  assign res_y = res[1];
  assign res_z = res[2];

  assign b0 = m[m_idx(2'd0, col)];
  assign b1 = m[m_idx(2'd1, col)];
  assign b2 = m[m_idx(2'd2, col)];
  assign sat_acc = sat32(acc);

  // the next and the one after, cyclic over x y z
  assign g1 = (grp == 2'd2) ? 2'd0 : grp + 2'd1;
  assign g2 = (grp == 2'd0) ? 2'd2 : grp - 2'd1;

  assign n_terms = (phase == 2'd0 && !is_xf) ? 3'd3 : (is_xf ? 3'd3 : 3'd4);
  assign last_term = (term == n_terms);

  always_comb begin
    mac_req = '0;
    mac_req.first = (term == 3'd0);
    mac_en = (state == S_RUN) && !last_term;
    if (is_xf) begin
      mac_req.a = m[m_idx(grp, term[1:0])];
      mac_req.b = v[term[1:0]];
    end else if (phase == 2'd0) begin
      case ({grp, term[1:0]})
        4'b0000: begin mac_req.a = q[1]; mac_req.b = b2; end
        4'b0001: begin mac_req.a = q[2]; mac_req.b = b1; mac_req.neg = 1'b1; end
        4'b0010: begin mac_req.a = q[3]; mac_req.b = b0; end
        4'b0100: begin mac_req.a = q[2]; mac_req.b = b0; end
        4'b0101: begin mac_req.a = q[0]; mac_req.b = b2; mac_req.neg = 1'b1; end
        4'b0110: begin mac_req.a = q[3]; mac_req.b = b1; end
        4'b1000: begin mac_req.a = q[0]; mac_req.b = b1; end
        4'b1001: begin mac_req.a = q[1]; mac_req.b = b0; mac_req.neg = 1'b1; end
        4'b1010: begin mac_req.a = q[3]; mac_req.b = b2; end
        4'b1100: begin mac_req.a = q[0]; mac_req.b = b0; mac_req.neg = 1'b1; end
        4'b1101: begin mac_req.a = q[1]; mac_req.b = b1; mac_req.neg = 1'b1; end
        4'b1110: begin mac_req.a = q[2]; mac_req.b = b2; mac_req.neg = 1'b1; end
        default: ;
      endcase
    end else begin
      // new basis entry grp: cross(q,p)[grp] - pw*q[grp] + qw*p[grp]
      case (term[1:0])
        2'd0: begin mac_req.a = q[g1]; mac_req.b = p[g2]; end
        2'd1: begin
          mac_req.a = q[g2]; mac_req.b = p[g1];
          mac_req.neg = 1'b1;
        end
        2'd2: begin mac_req.a = p[3]; mac_req.b = q[grp]; mac_req.neg = 1'b1; end
        default: begin mac_req.a = q[3]; mac_req.b = p[grp]; end
      endcase
    end
  end

  // the accumulator lags the request by the product and accumulator registers; wait before reading
  logic [1:0] drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 9; i++) m[i] <= (i % 4 == 0) ? ONE_ROT : '0;
      for (int i = 0; i < 3; i++) org[i] <= '0;
      drain <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            v[0] <= vec_x; v[1] <= vec_y; v[2] <= vec_z;
            q[0] <= quat_x; q[1] <= quat_y; q[2] <= quat_z; q[3] <= quat_w;
            col <= '0; grp <= '0; term <= '0; phase <= '0; drain <= '0;
            is_xf <= (action == ACT_TRANSFORM);
            case (action)
              ACT_LOAD: begin
                if (row_select == 2'd3) begin
                  org[0] <= vec_x; org[1] <= vec_y; org[2] <= vec_z;
                end else begin
                  m[m_idx(row_select, 2'd0)] <= vec_x;
                  m[m_idx(row_select, 2'd1)] <= vec_y;
                  m[m_idx(row_select, 2'd2)] <= vec_z;
                end
              end
              ACT_UPDATE: begin
                org[0] <= sat32(ACC_W'(org[0]) + ACC_W'(vec_x));
                org[1] <= sat32(ACC_W'(org[1]) + ACC_W'(vec_y));
                org[2] <= sat32(ACC_W'(org[2]) + ACC_W'(vec_z));
                state <= S_RUN;
              end
              ACT_TRANSFORM: state <= S_RUN;
              default: begin
                for (int i = 0; i < 9; i++) m[i] <= (i % 4 == 0) ? ONE_ROT : '0;
                for (int i = 0; i < 3; i++) org[i] <= '0;
              end
            endcase
          end
        end
        S_RUN: begin
          if (!last_term) begin
            term <= term + 3'd1;
          end else if (drain != 2'd2) begin
            drain <= drain + 2'd1;
          end else begin
            drain <= '0;
            term  <= '0;
            if (is_xf) begin
              res[grp] <= sat32(acc + ACC_W'(org[grp]));
              if (grp == 2'd2) state <= S_OUT;
              grp <= grp + 2'd1;
            end else if (phase == 2'd0) begin
              p[grp] <= sat_acc;
              if (grp == 2'd3) begin
                grp <= '0; phase <= 2'd1;
              end else begin
                grp <= grp + 2'd1;
              end
            end else begin
              m[m_idx(grp, col)] <= sat_acc;
              if (grp == 2'd2) begin
                grp <= '0; phase <= '0;
                if (col == 2'd2) state <= S_IDLE;
                col <= col + 2'd1;
              end else begin
                grp <= grp + 2'd1;
              end
            end
          end
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_valid |-> !in_ready)
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !res_ready) |=> state == S_OUT)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid && action != ACT_UPDATE && action != ACT_TRANSFORM) |=> in_ready)
    else $error("single-cycle action stalled");

endmodule

@@ rtl/rigid_pose_update_and_transform_top.sv @@
// Rigid pose unit: keeps a 3x3 basis (Q1.30) and an origin (Q16.16).
// Input channel (in_valid/in_ready) carries one word per action:
//   load row / origin, update by motion, transform point, set identity.
// Output channel (out_valid/out_ready) carries one transformed point per
// transform action; other actions give no output word.
// All arithmetic runs through one shared 32x32 multiply-accumulate unit,
// two pipeline stages deep, under a small sequencer.
// Load and identity finish in the accept cycle. Transform works through 3 rows
// (3 products, then a drain wait) and adds the origin, then the
// result is shown; the next word can be taken the cycle after it leaves.
// Update works through 3 columns (4 p-sums of 3 terms and 3 basis sums of
// 4 terms, each followed by a drain wait); the drain waits cover the
// accumulator latency of the multiply unit.
// in_ready is low while an action runs and while a result waits.
// A stalled receiver holds the result and the block until out_ready.
// Reset (rst, synchronous) sets the basis to identity and origin to zero.
module rigid_pose_update_and_transform_top import rpu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [1:0]         row_select,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic signed [31:0] quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z
);

  logic                    mac_en;
  mac_req_t                mac_req;
  logic signed [ACC_W-1:0] acc;

  rpu_mac u_mac (
    .clk(clk), .rst(rst), .en(mac_en), .req(mac_req), .acc(acc)
  );

  rpu_seq u_seq (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .row_select(row_select),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .mac_en(mac_en), .mac_req(mac_req), .acc(acc),
    .res_valid(out_valid), .res_ready(out_ready),
    .res_x(point_x), .res_y(point_y), .res_z(point_z)
  );

endmodule
